@@ rtl/fta_pkg.sv @@
// ----------------------------------------------------------------------------
// fta_pkg
// Shared types, constants and helpers of the frame time window averager.
// ----------------------------------------------------------------------------
`default_nettype none

package fta_pkg;

    // Default configuration
    localparam int WINDOW_DEF    = 120;
    localparam int TIME_BITS_DEF = 32;

    // Output widths and rate scaling (16 x one million microseconds)
    localparam int          OUT_W      = 32;
    localparam int          RATE_W     = 24;
    localparam logic [RATE_W-1:0] RATE_SCALE = 24'd16000000;

    // Ring access request for one cycle
    typedef struct packed {
        logic rd;   // read the entry at the write position
        logic wr;   // write the entry and advance the position
    } t_ring_cmd;

    // Clamp a wide value to the 32-bit output range
    function automatic logic [OUT_W-1:0] sat32(input logic [63:0] v);
        logic [OUT_W-1:0] r;
        if (v > 64'h0000_0000_FFFF_FFFF) begin
            r = '1;
        end else begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/frame_time_window_averager.sv @@
// ----------------------------------------------------------------------------
// frame_time_window_averager
// Frame time, instant rate and boxcar window average of frame marks.
// ----------------------------------------------------------------------------
// Each accepted beat is a frame mark with a free-running microsecond stamp.
// The block returns one result beat per mark: the saturating frame count, the
// frame time since the previous mark (modulo 2^TIME_BITS, first mark measured
// from zero), the instant rate in 1/16 fps, and once WINDOW frames have been
// counted the window average time and average rate (zero before that). All
// divisions run on one shared bit-serial divider, one quotient bit per cycle,
// one after another: the instant rate for every mark, and the window average
// and the average rate once the window is full, before the next mark is taken.
// A new mark is taken while the previous result still waits at the output.
// The ring needs no clearing after reset: entries not yet overwritten in the
// first lap count as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_time_window_averager #(
    parameter int WINDOW    = fta_pkg::WINDOW_DEF,
    parameter int TIME_BITS = fta_pkg::TIME_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // mark channel
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [31:0] i_time_stamp_us,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [31:0]      o_frames_seen,
    output logic [31:0]      o_frame_time_us,
    output logic [23:0]      o_instant_rate_q4,
    output logic             o_average_valid,
    output logic [31:0]      o_average_time_us,
    output logic [23:0]      o_average_rate_q4
);

    localparam int RATE_W = fta_pkg::RATE_W;
    localparam int OUT_W  = fta_pkg::OUT_W;
    localparam int SUM_W  = TIME_BITS + $clog2(WINDOW);
    localparam int DVD_W  = (SUM_W > RATE_W) ? SUM_W : RATE_W;
    localparam int STEP_W = $clog2(DVD_W + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_RATE,
        S_AVG,
        S_ARATE,
        S_OUT
    } t_state_e;

    t_state_e             r_state, n_state;
    logic [TIME_BITS-1:0] r_prev,  n_prev;
    logic [OUT_W-1:0]     r_count, n_count;
    logic                 r_first, n_first;
    logic [TIME_BITS-1:0] r_ft,    n_ft;
    logic [SUM_W-1:0]     r_sum,   n_sum;
    logic [RATE_W-1:0]    r_irate, n_irate;
    logic [TIME_BITS-1:0] r_avg,   n_avg;
    logic [RATE_W-1:0]    r_arate, n_arate;

    logic                 r_out_valid,  n_out_valid;
    logic [OUT_W-1:0]     r_out_frames, n_out_frames;
    logic [OUT_W-1:0]     r_out_ft,     n_out_ft;
    logic [RATE_W-1:0]    r_out_irate,  n_out_irate;
    logic                 r_out_avalid, n_out_avalid;
    logic [OUT_W-1:0]     r_out_avg,    n_out_avg;
    logic [RATE_W-1:0]    r_out_arate,  n_out_arate;

    logic                 in_acc;
    logic [TIME_BITS-1:0] stamp;
    logic                 win_full;

    fta_pkg::t_ring_cmd   ring_cmd;
    logic [TIME_BITS-1:0] ring_rdata;

    logic                 div_start;
    logic [DVD_W-1:0]     div_dvd;
    logic [TIME_BITS-1:0] div_dvs;
    logic [STEP_W-1:0]    div_steps;
    logic                 div_busy;
    logic                 div_done;
    logic [DVD_W-1:0]     div_q;

    // Frame time store
    fta_ring #(
        .DEPTH  (WINDOW),
        .DATA_W (TIME_BITS)
    ) u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (ring_cmd),
        .i_wdata (r_ft),
        .o_rdata (ring_rdata)
    );

    // Shared divider for both rates and the window average
    fta_divider #(
        .DVD_W  (DVD_W),
        .DVS_W  (TIME_BITS),
        .STEP_W (STEP_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .i_steps    (div_steps),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign stamp      = TIME_BITS'(i_time_stamp_us);
    assign win_full   = (r_count >= OUT_W'(WINDOW));

    // Sequencer: frame time, ring update, then up to three divisions
    always_comb begin
        n_state      = r_state;
        n_prev       = r_prev;
        n_count      = r_count;
        n_first      = r_first;
        n_ft         = r_ft;
        n_sum        = r_sum;
        n_irate      = r_irate;
        n_avg        = r_avg;
        n_arate      = r_arate;
        n_out_valid  = r_out_valid;
        n_out_frames = r_out_frames;
        n_out_ft     = r_out_ft;
        n_out_irate  = r_out_irate;
        n_out_avalid = r_out_avalid;
        n_out_avg    = r_out_avg;
        n_out_arate  = r_out_arate;
        ring_cmd     = '0;
        div_start    = 1'b0;
        div_dvd      = '0;
        div_dvs      = '0;
        div_steps    = '0;

        // result beat taken
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_ft    = stamp - r_prev;
                    n_prev  = stamp;
                    n_first = (r_count < OUT_W'(WINDOW));
                    n_count = (r_count == '1) ? r_count : r_count + 1'b1;
                    ring_cmd.rd = 1'b1;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                // entries not yet written in the first lap are zero
                n_sum = r_sum - (r_first ? '0 : SUM_W'(ring_rdata)) + SUM_W'(r_ft);
                ring_cmd.wr = 1'b1;
                div_start   = 1'b1;
                div_dvd     = DVD_W'(fta_pkg::RATE_SCALE) << (DVD_W - RATE_W);
                div_dvs     = r_ft;
                div_steps   = STEP_W'(RATE_W);
                n_state     = S_RATE;
            end
            S_RATE: begin
                if (div_done) begin
                    n_irate = (r_ft == '0) ? fta_pkg::RATE_SCALE : div_q[RATE_W-1:0];
                    if (win_full) begin
                        div_start = 1'b1;
                        div_dvd   = DVD_W'(r_sum) << (DVD_W - SUM_W);
                        div_dvs   = TIME_BITS'(WINDOW);
                        div_steps = STEP_W'(SUM_W);
                        n_state   = S_AVG;
                    end else begin
                        n_avg   = '0;
                        n_arate = '0;
                        n_state = S_OUT;
                    end
                end
            end
            S_AVG: begin
                if (div_done) begin
                    n_avg     = div_q[TIME_BITS-1:0];
                    div_start = 1'b1;
                    div_dvd   = DVD_W'(fta_pkg::RATE_SCALE) << (DVD_W - RATE_W);
                    div_dvs   = div_q[TIME_BITS-1:0];
                    div_steps = STEP_W'(RATE_W);
                    n_state   = S_ARATE;
                end
            end
            S_ARATE: begin
                if (div_done) begin
                    n_arate = (r_avg == '0) ? fta_pkg::RATE_SCALE : div_q[RATE_W-1:0];
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_frames = r_count;
                    n_out_ft     = fta_pkg::sat32(64'(r_ft));
                    n_out_irate  = r_irate;
                    n_out_avalid = win_full;
                    n_out_avg    = fta_pkg::sat32(64'(r_avg));
                    n_out_arate  = r_arate;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prev      <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_prev      <= n_prev;
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
        r_first      <= n_first;
        r_ft         <= n_ft;
        r_irate      <= n_irate;
        r_avg        <= n_avg;
        r_arate      <= n_arate;
        r_out_frames <= n_out_frames;
        r_out_ft     <= n_out_ft;
        r_out_irate  <= n_out_irate;
        r_out_avalid <= n_out_avalid;
        r_out_avg    <= n_out_avg;
        r_out_arate  <= n_out_arate;
    end

    assign o_out_valid       = r_out_valid;
    assign o_frames_seen     = r_out_frames;
    assign o_frame_time_us   = r_out_ft;
    assign o_instant_rate_q4 = r_out_irate;
    assign o_average_valid   = r_out_avalid;
    assign o_average_time_us = r_out_avg;
    assign o_average_rate_q4 = r_out_arate;

    // Checks
    a_idle_div_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !div_busy)
        else $error("divider busy while a mark is accepted");

    a_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_RATE || r_state == S_AVG || r_state == S_ARATE))
        else $error("divider finished outside a division state");

    a_avg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_average_valid) |->
            (o_average_time_us == '0 && o_average_rate_q4 == '0))
        else $error("average fields not zero before the window is full");

    a_rate_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_instant_rate_q4 <= fta_pkg::RATE_SCALE &&
                         o_average_rate_q4 <= fta_pkg::RATE_SCALE))
        else $error("rate above full scale");

endmodule

`default_nettype wire

@@ rtl/fta_ring.sv @@
// ----------------------------------------------------------------------------
// fta_ring
// Ring store of frame times with its own write position; registered read at
// the position that the next write will overwrite.
// ----------------------------------------------------------------------------
`default_nettype none

module fta_ring #(
    parameter int DEPTH  = fta_pkg::WINDOW_DEF,
    parameter int DATA_W = fta_pkg::TIME_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire fta_pkg::t_ring_cmd i_cmd,
    input  wire logic [DATA_W-1:0] i_wdata,
    output logic      [DATA_W-1:0] o_rdata
);

    localparam int PTR_W = $clog2(DEPTH);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_ptr;
    logic [DATA_W-1:0] r_rdata;

    // Write position, wraps at the last entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else if (i_cmd.wr) begin
            if (r_ptr == PTR_W'(DEPTH - 1)) begin
                r_ptr <= '0;
            end else begin
                r_ptr <= r_ptr + 1'b1;
            end
        end
    end

    // Storage: one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem[r_ptr] <= i_wdata;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[r_ptr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/fta_divider.sv @@
// ----------------------------------------------------------------------------
// fta_divider
// Bit-serial restoring divider: one quotient bit per cycle. The dividend is
// loaded left-aligned and shifted out MSB first while quotient bits shift in.
// ----------------------------------------------------------------------------
`default_nettype none

module fta_divider #(
    parameter int DVD_W  = 39,
    parameter int DVS_W  = fta_pkg::TIME_BITS_DEF,
    parameter int STEP_W = $clog2(DVD_W + 1)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DVD_W-1:0]  i_dividend,
    input  wire logic [DVS_W-1:0]  i_divisor,
    input  wire logic [STEP_W-1:0] i_steps,
    output logic                   o_busy,
    output logic                   o_done,
    output logic      [DVD_W-1:0]  o_quotient
);

    logic [DVD_W-1:0]  r_dq;
    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_dvs;
    logic [STEP_W-1:0] r_cnt;
    logic              r_done;

    logic [DVS_W:0]    trial;
    logic              q_bit;
    logic [DVS_W:0]    diff;

    // One restoring step: bring in the next dividend bit, try the subtract
    always_comb begin
        trial = {r_rem, r_dq[DVD_W-1]};
        diff  = trial - {1'b0, r_dvs};
        q_bit = (trial >= {1'b0, r_dvs});
    end

    // Control is reset, data path is not
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= i_steps;
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - 1'b1;
            r_done <= (r_cnt == STEP_W'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dq  <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_dq  <= {r_dq[DVD_W-2:0], q_bit};
            r_rem <= q_bit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        end
    end

    assign o_busy     = (r_cnt != '0);
    assign o_done     = r_done;
    assign o_quotient = r_dq;

endmodule

`default_nettype wire
